// ===== hw/rtl/twlk_pkg.sv =====
package twlk_pkg;

   localparam logic [15:0] PHASE_LENGTH_RESET = 16'd9000;

   // operation codes
   localparam logic [1:0] OP_RAW_WRITE   = 2'd0;
   localparam logic [1:0] OP_DIGIT_WRITE = 2'd1;
   localparam logic [1:0] OP_KEY_READ    = 2'd2;

   localparam logic [2:0] DIGIT_INDEX_MAX = 3'd4;
   localparam logic [7:0] DIGIT_CMD_BASE  = 8'h68;
   localparam logic [7:0] KEY_READ_CMD    = 8'h4F;

   // line phases of one transaction
   localparam logic [5:0] PH_IDLE          = 6'd0;
   localparam logic [5:0] PH_START         = 6'd1;
   localparam logic [5:0] PH_BYTE0_FIRST   = 6'd2;
   localparam logic [5:0] PH_BYTE0_LAST    = 6'd25;
   localparam logic [5:0] PH_ACK0_LOW      = 6'd26;
   localparam logic [5:0] PH_ACK0_RELEASE  = 6'd27;
   localparam logic [5:0] PH_ACK0_HIGH     = 6'd28;
   localparam logic [5:0] PH_BYTE1_FIRST   = 6'd29;
   localparam logic [5:0] PH_BYTE1_LAST    = 6'd52;
   localparam logic [5:0] PH_ACK1_LOW      = 6'd53;
   localparam logic [5:0] PH_ACK1_RELEASE  = 6'd54;
   localparam logic [5:0] PH_ACK1_HIGH     = 6'd55;
   localparam logic [5:0] PH_STOP_LOW      = 6'd56;
   localparam logic [5:0] PH_STOP_SDA_LOW  = 6'd57;
   localparam logic [5:0] PH_STOP_HIGH     = 6'd58;
   localparam logic [5:0] PH_LAST          = 6'd59;

   // step within one bit of a byte
   localparam logic [1:0] SUB_CLK_LOW  = 2'd0;
   localparam logic [1:0] SUB_DATA     = 2'd1;
   localparam logic [1:0] SUB_CLK_HIGH = 2'd2;

   typedef struct packed {
      logic       start_req;
      logic [1:0] operation;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [2:0] digit_index;
      logic [3:0] digit_value;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic       rejected;
      logic       key_valid;
      logic [7:0] key_raw;
      logic [5:0] key_code;
   } rsp_item_type;

   function automatic logic [7:0] seg_pattern(input logic [3:0] value);
      logic [7:0] pat;
      case (value)
         4'h0: pat = 8'h3f;
         4'h1: pat = 8'h06;
         4'h2: pat = 8'h5b;
         4'h3: pat = 8'h4f;
         4'h4: pat = 8'h66;
         4'h5: pat = 8'h6d;
         4'h6: pat = 8'h7d;
         4'h7: pat = 8'h07;
         4'h8: pat = 8'h7f;
         4'h9: pat = 8'h6f;
         4'ha: pat = 8'h77;
         4'hb: pat = 8'h7c;
         4'hc: pat = 8'h39;
         4'hd: pat = 8'h5e;
         4'he: pat = 8'h79;
         4'hf: pat = 8'h71;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

// ===== hw/rtl/twlk_core.sv =====
module twlk_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [15:0]            csr_write_data,
   input  logic                   step,
   input  twlk_pkg::req_item_type item,
   output twlk_pkg::rsp_item_type result
);
   import twlk_pkg::*;

   logic [15:0] phase_length_ff;
   logic [5:0]  phase_ff, phase_in;
   logic [1:0]  sub_ff, sub_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  held_ff, held_in;
   logic        read_mode_ff, read_mode_in;
   logic        busy_ff, busy_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in_next;
   logic        drive_ff, drive_in;

   logic [15:0] tick_inc;
   logic [5:0]  phase_next;
   logic [1:0]  sub_next;
   logic        in_byte0, in_byte1;

   assign tick_inc   = tick_ff + 16'd1;
   assign phase_next = phase_ff + 6'd1;
   assign sub_next   = (sub_ff == SUB_CLK_HIGH) ? SUB_CLK_LOW : sub_ff + 2'd1;
   assign in_byte0   = (phase_next >= PH_BYTE0_FIRST) && (phase_next <= PH_BYTE0_LAST);
   assign in_byte1   = (phase_next >= PH_BYTE1_FIRST) && (phase_next <= PH_BYTE1_LAST);

   always_comb begin
      logic       reading;
      logic [7:0] raw;
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      held_in      = held_ff;
      read_mode_in = read_mode_ff;
      busy_in      = busy_ff;
      scl_in       = scl_ff;
      sda_in_next  = sda_ff;
      drive_in     = drive_ff;
      reading      = 1'b0;
      raw          = 8'h00;
      result       = '0;

      if (busy_ff) begin
         tick_in = tick_inc;
         // a zero length behaves as one
         if (tick_inc >= phase_length_ff) begin
            tick_in  = '0;
            phase_in = phase_next;
            sub_in   = sub_next;
            if (phase_ff == PH_LAST) begin
               phase_in        = PH_IDLE;
               busy_in         = 1'b0;
               result.done_res = 1'b1;
               scl_in          = 1'b1;
               sda_in_next     = 1'b1;
               drive_in        = 1'b1;
               if (read_mode_ff) begin
                  raw              = shift_ff;
                  result.key_valid = 1'b1;
                  result.key_raw   = raw;
                  if (raw[6]) begin
                     result.key_code = {1'b0, raw[5:3], raw[1:0]} + 6'd1;
                  end
               end
            end else if (in_byte0 || in_byte1) begin
               reading = in_byte1 && read_mode_ff;
               if (phase_next == PH_BYTE1_FIRST) begin
                  if (read_mode_ff) begin
                     shift_in = 8'h00;
                     drive_in = 1'b0;
                  end else begin
                     shift_in = held_ff;
                  end
               end
               case (sub_next)
                  SUB_CLK_LOW: begin
                     scl_in = 1'b0;
                  end
                  SUB_DATA: begin
                     if (reading) begin
                        shift_in = {shift_ff[6:0], item.sda_in};
                     end else begin
                        sda_in_next = shift_ff[7];
                     end
                  end
                  SUB_CLK_HIGH: begin
                     scl_in = 1'b1;
                     if (!reading) begin
                        shift_in = {shift_ff[6:0], 1'b0};
                     end
                  end
                  default: begin
                     scl_in = scl_ff;
                  end
               endcase
            end else begin
               case (phase_next)
                  PH_START, PH_STOP_SDA_LOW: begin
                     sda_in_next = 1'b0;
                  end
                  PH_ACK0_LOW, PH_ACK1_LOW, PH_STOP_LOW: begin
                     scl_in = 1'b0;
                  end
                  PH_ACK0_RELEASE: begin
                     sda_in_next = 1'b1;
                  end
                  PH_ACK0_HIGH, PH_ACK1_HIGH, PH_STOP_HIGH: begin
                     scl_in = 1'b1;
                  end
                  PH_ACK1_RELEASE: begin
                     sda_in_next = 1'b1;
                     drive_in    = 1'b1;
                  end
                  PH_LAST: begin
                     sda_in_next = 1'b1;
                  end
                  default: begin
                     scl_in = scl_ff;
                  end
               endcase
            end
         end
      end else if (item.start_req) begin
         case (item.operation)
            OP_RAW_WRITE: begin
               shift_in     = item.first_byte;
               held_in      = item.second_byte;
               read_mode_in = 1'b0;
               busy_in      = 1'b1;
            end
            OP_DIGIT_WRITE: begin
               if (item.digit_index > DIGIT_INDEX_MAX) begin
                  result.rejected = 1'b1;
               end else begin
                  shift_in     = DIGIT_CMD_BASE + {4'd0, item.digit_index, 1'b0};
                  held_in      = seg_pattern(item.digit_value);
                  read_mode_in = 1'b0;
                  busy_in      = 1'b1;
               end
            end
            OP_KEY_READ: begin
               shift_in     = KEY_READ_CMD;
               held_in      = 8'h00;
               read_mode_in = 1'b1;
               busy_in      = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
         if (busy_in) begin
            phase_in = PH_IDLE;
            sub_in   = SUB_DATA;
            tick_in  = '0;
         end
      end

      result.scl       = scl_in;
      result.sda_out   = sda_in_next;
      result.sda_drive = drive_in;
      result.busy_res  = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_length_ff <= PHASE_LENGTH_RESET;
      end else if (csr_write_enable) begin
         phase_length_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sub_ff       <= SUB_DATA;
         tick_ff      <= '0;
         shift_ff     <= '0;
         held_ff      <= '0;
         read_mode_ff <= 1'b0;
         busy_ff      <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         drive_ff     <= 1'b1;
      end else if (step) begin
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         tick_ff      <= tick_in;
         shift_ff     <= shift_in;
         held_ff      <= held_in;
         read_mode_ff <= read_mode_in;
         busy_ff      <= busy_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in_next;
         drive_ff     <= drive_in;
      end
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_LAST)
      else $error("phase index out of range");

   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (phase_ff == PH_IDLE && scl_ff && sda_ff && drive_ff))
      else $error("lines not released while idle");

   a_release_only_read: assert property (@(posedge clock) disable iff (reset)
      !drive_ff |-> (busy_ff && read_mode_ff && phase_ff >= PH_BYTE1_FIRST))
      else $error("data line released outside read byte");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      (step && busy_ff && result.done_res) |=> !busy_ff)
      else $error("transaction did not end with done");

endmodule

// ===== hw/rtl/two_wire_led_key_bus_master.sv =====
// Two-wire bus master for an LED-digit and key controller.
// Each item on the req_ channel is one tick of the phase timer and yields
// exactly one item on the rsp_ channel with the line levels and status after
// that tick. A tick with start_req set while idle launches a raw write, a
// digit write (rejected if the index exceeds 4) or a key read; each
// transaction runs 60 line phases of phase_length ticks each, set through
// csr_write_enable/csr_write_data (write only while no item is in flight).
// An accepted item is taken into the input register, processed by the phase
// logic when it advances and captured in the result register, from which it
// is shown on rsp_.
// Throughput: one item per cycle while the receiver does not stall; the phase
// counter and line state advance once per item in a single registered pass.
// When the receiver stalls, the result register holds and the input register
// fills; req_stall then rises until the result is taken. Time counts in
// items, so a stall freezes the bus timing.
// Reset: both stages empty, bus idle with clock and data high and driven,
// phase length 9000 ticks.
module two_wire_led_key_bus_master (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  twlk_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output twlk_pkg::rsp_item_type rsp_item,
   input  logic                   csr_write_enable,
   input  logic [15:0]            csr_write_data
);
   import twlk_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type step_result;
   logic         advance;
   logic         accept;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   twlk_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (advance),
      .item             (in_item_ff),
      .result           (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule
